### hw/rtl/dfor_pkg.sv
// shared types and constants for the dictionary frame-of-reference codec
// no dependencies

package dfor_pkg;

	localparam int DICT_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(DICT_DEPTH);
	localparam int CODE_W     = 10;
	localparam int DATA_W     = 32;
	localparam int ENTRY_W    = DATA_W + 1;

	localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_BUILD  = 3'd1,
		OP_ENCODE = 3'd2,
		OP_DECODE = 3'd3,
		OP_LOAD   = 3'd4,
		OP_READ   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic sweep;
		logic sweep_rst;
	} dp_cmd_t;

	typedef struct packed {
		logic op_clear;
		logic sweep_last;
	} dp_sts_t;

endpackage

### hw/rtl/dictionary_frame_of_reference_codec.sv
// top level of the dictionary frame-of-reference codec
// depends on dfor_pkg, dfor_ctrl, dfor_dp and dfor_ram
//
// usage:
//   a row is taken at a rising edge where start is high and busy is low;
//   op selects clear, build, encode, decode, load or read of a reference.
//   every row gives one result beat: done is high for exactly one cycle
//   with result_value and result_valid; the receiver cannot stall.
// timing:
//   the row and the ram read are registered at the accepting edge, the
//   result at the end of the execute cycle; busy is high in the execute
//   cycle after acceptance, so a new row waits until execute is over.
//   the execute cycle does the read-modify-write of the reference ram.
//   a clear gives its result beat and keeps busy high while it sweeps the
//   seen bits out of all DICT_DEPTH (1024) entries of the ram, one entry a
//   cycle.
// reset:
//   arst_n low clears the control state and the null reference; after
//   release the same sweep runs with busy high before the first row can be
//   accepted.

module dictionary_frame_of_reference_codec
	import dfor_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         op,
	input  logic [CODE_W-1:0]  code,
	input  logic               source_valid,
	input  logic               target_valid,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               result_valid
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	dfor_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	dfor_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.code         (code),
		.source_valid (source_valid),
		.target_valid (target_valid),
		.value        (value),
		.done         (done),
		.result_value (result_value),
		.result_valid (result_valid)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted beat");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat longer than one cycle");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without an accepted row");

endmodule

### hw/rtl/dfor_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module dfor_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/dfor_ctrl.sv
// controller state machine for the codec: accept, execute, clearing sweep
// depends on dfor_pkg

module dfor_ctrl
	import dfor_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				if (sts.op_clear) begin
					cmd.sweep_rst = 1'b1;
					state_d       = ST_CLEAR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q != ST_EXEC)
		else $error("execute state held for more than one cycle");

endmodule

### hw/rtl/dfor_dp.sv
// datapath for the codec: captured row, reference ram, null reference, result
// depends on dfor_pkg and dfor_ram

module dfor_dp
	import dfor_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [2:0]         op,
	input  logic [CODE_W-1:0]  code,
	input  logic               source_valid,
	input  logic               target_valid,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] result_value,
	output logic               result_valid
);

	logic [2:0]         op_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               in_range_q;
	logic               src_q;
	logic               tgt_q;
	logic [DATA_W-1:0]  value_q;
	logic [DATA_W-1:0]  null_ref_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               done_q;
	logic [DATA_W-1:0]  res_q;
	logic               res_valid_q;

	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	logic [DATA_W-1:0]  row_ref;
	logic [DATA_W-1:0]  min_ref;
	logic [DATA_W-1:0]  null_d;
	logic [DATA_W-1:0]  res_d;
	logic               res_valid_d;
	logic               tbl_wr;
	logic [DATA_W-1:0]  tbl_data;

	dfor_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DICT_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.capture),
		.rd_addr (ADDR_W'(code)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= op;
			addr_q     <= ADDR_W'(code);
			in_range_q <= 32'(code) < DICT_DEPTH;
			src_q      <= source_valid;
			tgt_q      <= target_valid;
			value_q    <= value;
		end
	end

	// reference of the captured row
	always_comb begin
		if (!src_q) begin
			row_ref = null_ref_q;
		end else if (in_range_q && rd_data[DATA_W]) begin
			row_ref = rd_data[DATA_W-1:0];
		end else begin
			row_ref = INT_MAX;
		end
		min_ref = ($signed(row_ref) <= $signed(value_q)) ? row_ref : value_q;
	end

	always_comb begin
		null_d      = null_ref_q;
		res_d       = '0;
		res_valid_d = 1'b1;
		tbl_wr      = 1'b0;
		tbl_data    = value_q;
		case (op_q)
			OP_CLEAR: begin
				null_d = INT_MAX;
			end
			OP_BUILD: begin
				if (tgt_q) begin
					if (!src_q) begin
						null_d = min_ref;
					end else begin
						tbl_wr   = in_range_q;
						tbl_data = min_ref;
					end
				end
			end
			OP_ENCODE: begin
				res_valid_d = tgt_q;
				res_d       = tgt_q ? value_q - row_ref : value_q;
			end
			OP_DECODE: begin
				res_valid_d = tgt_q;
				res_d       = tgt_q ? value_q + row_ref : value_q;
			end
			OP_LOAD: begin
				if (!src_q) begin
					null_d = value_q;
				end else begin
					tbl_wr = in_range_q;
				end
			end
			OP_READ: begin
				res_d = row_ref;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	assign wr_en   = cmd.sweep || (cmd.execute && tbl_wr);
	assign wr_addr = cmd.sweep ? clr_q : addr_q;
	assign wr_data = cmd.sweep ? '0 : {1'b1, tbl_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_ref_q <= INT_MAX;
			clr_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.execute) begin
				null_ref_q <= null_d;
			end
			if (cmd.sweep_rst) begin
				clr_q <= '0;
			end else if (cmd.sweep) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_q       <= res_d;
			res_valid_q <= res_valid_d;
		end
	end

	assign sts.op_clear   = (op_q == OP_CLEAR);
	assign sts.sweep_last = (clr_q == ADDR_W'(DICT_DEPTH - 1));

	assign done         = done_q;
	assign result_value = res_q;
	assign result_valid = res_valid_q;

endmodule

### dv/dfor_scoreboard_pkg.sv
// scoreboard for the dictionary frame-of-reference codec: predicts each result beat
// from its own copy of the reference table and checks the beats in order
// depends on dfor_pkg
`timescale 1ns / 1ps

package dfor_scoreboard_pkg;
	import dfor_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              valid;
	} codec_beat_t;

	class codec_scoreboard;
		logic [DATA_W-1:0] base_table [DICT_DEPTH];
		bit                base_seen  [DICT_DEPTH];
		logic [DATA_W-1:0] null_base;
		codec_beat_t       pending_beats [$];
		int                errors;

		function new();
			foreach (base_seen[i]) begin
				base_seen[i]  = 1'b0;
				base_table[i] = '0;
			end
			null_base = INT_MAX;
			errors    = 0;
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		function logic [DATA_W-1:0] lower_of(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			return ($signed(a) <= $signed(b)) ? a : b;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10) begin
				$display("mismatch at %0t: %s", $time, what);
			end
		endfunction

		function void note_row(op_t row_op, logic [CODE_W-1:0] row_code, logic src_ok,
				logic tgt_ok, logic [DATA_W-1:0] row_value);
			logic [DATA_W-1:0] base;
			codec_beat_t       beat;
			if (!src_ok)
				base = null_base;
			else if (base_seen[row_code])
				base = base_table[row_code];
			else
				base = INT_MAX;
			beat.value = '0;
			beat.valid = 1'b1;
			case (row_op)
				OP_CLEAR: begin
					foreach (base_seen[i]) base_seen[i] = 1'b0;
					null_base = INT_MAX;
				end
				OP_BUILD: begin
					if (tgt_ok && !src_ok) begin
						null_base = lower_of(null_base, row_value);
					end else if (tgt_ok) begin
						base_table[row_code] = lower_of(base, row_value);
						base_seen[row_code]  = 1'b1;
					end
				end
				OP_ENCODE: begin
					beat.valid = tgt_ok;
					beat.value = tgt_ok ? row_value - base : row_value;
				end
				OP_DECODE: begin
					beat.valid = tgt_ok;
					beat.value = tgt_ok ? row_value + base : row_value;
				end
				OP_LOAD: begin
					if (!src_ok) begin
						null_base = row_value;
					end else begin
						base_table[row_code] = row_value;
						base_seen[row_code]  = 1'b1;
					end
				end
				OP_READ: begin
					beat.value = base;
				end
				default: begin
				end
			endcase
			pending_beats.insert(pending_beats.size(), beat);
		endfunction

		function void check_result(logic [DATA_W-1:0] got_value, logic got_valid);
			codec_beat_t want;
			if (pending_beats.size() == 0) begin
				flag($sformatf("unexpected beat value %h valid %b", got_value, got_valid));
			end else begin
				want = pending_beats.pop_front();
				if (want.value !== got_value || want.valid !== got_valid) begin
					flag($sformatf("value %h valid %b, expected value %h valid %b",
						got_value, got_valid, want.value, want.valid));
				end
			end
		endfunction

		function void close();
			errors += pending_beats.size();
		endfunction
	endclass

endpackage

### dv/tb_top.sv
// top-level testbench for dictionary_frame_of_reference_codec: directed rows, then
// random rows over several sender idling phases, checked by codec_scoreboard
// depends on dfor_pkg, dfor_scoreboard_pkg and the codec rtl
`timescale 1ns / 1ps

module tb_top;
	import dfor_pkg::*;
	import dfor_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         op;
	logic [CODE_W-1:0]  code;
	logic               source_valid;
	logic               target_valid;
	logic signed [31:0] value;
	logic               done;
	logic signed [31:0] result_value;
	logic               result_valid;

	codec_scoreboard sb = new();
	int              gap_pct = 0;
	int              cycles = 0;

	dictionary_frame_of_reference_codec uut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("dictionary_frame_of_reference_codec test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (done) begin
			sb.check_result(result_value, result_valid);
		end
	end

	task automatic send_row(op_t row_op, logic [CODE_W-1:0] row_code, logic src_ok,
			logic tgt_ok, logic [DATA_W-1:0] row_value);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start        <= 1'b1;
		op           <= row_op;
		code         <= row_code;
		source_valid <= src_ok;
		target_valid <= tgt_ok;
		value        <= row_value;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_row(row_op, row_code, src_ok, tgt_ok, row_value);
	endtask

	initial begin
		int                idle_plan [4] = '{0, 62, 23, 0};
		logic [DATA_W-1:0] corner_vals [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h1};
		int unsigned       pick;
		op_t               r_op;
		logic [CODE_W-1:0] r_code;
		logic [DATA_W-1:0] r_value;

		arst_n       <= 1'b0;
		start        <= 1'b0;
		op           <= OP_CLEAR;
		code         <= '0;
		source_valid <= 1'b0;
		target_valid <= 1'b0;
		value        <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// unseen entries and the null reference after reset
		send_row(OP_READ,   10'd0,   1'b1, 1'b1, 32'h0);
		send_row(OP_READ,   10'd0,   1'b0, 1'b1, 32'h0);
		send_row(OP_ENCODE, 10'd5,   1'b1, 1'b1, 32'hFFFF_FFFF);
		// build keeps the minimum, absent target changes nothing
		send_row(OP_BUILD,  10'd5,   1'b1, 1'b1, 32'd100);
		send_row(OP_BUILD,  10'd5,   1'b1, 1'b1, 32'd200);
		send_row(OP_BUILD,  10'd6,   1'b1, 1'b0, 32'd7);
		send_row(OP_READ,   10'd6,   1'b1, 1'b1, 32'h0);
		send_row(OP_BUILD,  10'd5,   1'b1, 1'b1, 32'h8000_0000);
		send_row(OP_ENCODE, 10'd5,   1'b1, 1'b1, 32'h7FFF_FFFF);
		send_row(OP_ENCODE, 10'd5,   1'b1, 1'b0, 32'h1234_5678);
		send_row(OP_DECODE, 10'd5,   1'b1, 1'b1, 32'h1);
		send_row(OP_DECODE, 10'd5,   1'b1, 1'b0, 32'h8000_0000);
		// null source rows
		send_row(OP_BUILD,  10'd3,   1'b0, 1'b1, 32'hFFFF_FFFB);
		send_row(OP_ENCODE, 10'd3,   1'b0, 1'b1, 32'd10);
		send_row(OP_LOAD,   10'd3,   1'b0, 1'b1, 32'h8000_0000);
		send_row(OP_READ,   10'd3,   1'b0, 1'b0, 32'h0);
		send_row(OP_DECODE, 10'd3,   1'b0, 1'b1, 32'hFFFF_FFFF);
		// top code, load then build
		send_row(OP_LOAD,   10'd1023, 1'b1, 1'b0, 32'h7FFF_FFFF);
		send_row(OP_BUILD,  10'd1023, 1'b1, 1'b1, 32'h8000_0000);
		send_row(OP_READ,   10'd1023, 1'b1, 1'b1, 32'h0);
		// clear drops every entry and the null reference
		send_row(OP_CLEAR,  10'd1023, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_row(OP_READ,   10'd5,   1'b1, 1'b1, 32'h0);
		send_row(OP_READ,   10'd5,   1'b0, 1'b1, 32'h0);
		send_row(OP_LOAD,   10'd0,   1'b1, 1'b1, 32'hFFFF_FFFF);
		send_row(OP_ENCODE, 10'd0,   1'b1, 1'b1, 32'h0);

		foreach (idle_plan[p]) begin
			gap_pct = idle_plan[p];
			repeat (256) begin
				pick = $urandom_range(0, 999);
				if (pick < 20)
					r_op = OP_CLEAR;
				else if (pick < 280)
					r_op = OP_BUILD;
				else if (pick < 530)
					r_op = OP_ENCODE;
				else if (pick < 730)
					r_op = OP_DECODE;
				else if (pick < 830)
					r_op = OP_LOAD;
				else
					r_op = OP_READ;
				// most rows share a few codes so builds feed later encodes
				pick = $urandom_range(0, 9);
				if (pick < 7)
					r_code = CODE_W'($urandom_range(0, 15));
				else if (pick == 7)
					r_code = CODE_W'(1023 - $urandom_range(0, 3));
				else
					r_code = CODE_W'($urandom);
				pick = $urandom_range(0, 9);
				if (pick < 2)
					r_value = corner_vals[$urandom_range(0, 4)];
				else if (pick < 6)
					r_value = DATA_W'($urandom_range(0, 4000)) - 32'd2000;
				else
					r_value = $urandom;
				send_row(r_op, r_code, $urandom_range(0, 99) < 85,
					$urandom_range(0, 99) < 85, r_value);
			end
			// hold off until the codec has drained
			start <= 1'b0;
			while (sb.pending() != 0) @(posedge clk);
		end

		repeat (16) @(posedge clk);
		sb.close();
		if (sb.errors == 0) begin
			$display("dictionary_frame_of_reference_codec test passed");
		end else begin
			$display("dictionary_frame_of_reference_codec test failed");
		end
		$finish;
	end

endmodule
